@@ rtl/core/gdpc_pkg.sv @@
`default_nettype none

package gdpc_pkg;

   // Widths of the register and counter fields.
   localparam int unsigned TicksWidth = 16;
   localparam int unsigned CountWidth = 3;

   // Configuration register indexes.
   localparam logic [1:0] CsrTimeoutTicks = 2'd0;
   localparam logic [1:0] CsrPulseTicks   = 2'd1;
   localparam logic [1:0] CsrMaxPulses    = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [TicksWidth-1:0] TimeoutTicksReset = 16'd30000;
   localparam logic [TicksWidth-1:0] PulseTicksReset   = 16'd500;
   localparam logic [CountWidth-1:0] MaxPulsesReset    = 3'd3;

   // Report codes.
   localparam logic [1:0] CodeClosed = 2'd0;
   localparam logic [1:0] CodeOpened = 2'd1;
   localparam logic [1:0] CodeError  = 2'd2;

   typedef struct packed {
      logic [TicksWidth-1:0] timeout_ticks;
      logic [TicksWidth-1:0] pulse_ticks;
      logic [CountWidth-1:0] max_pulses;
   } cfg_type;

   typedef struct packed {
      logic cmd_valid;
      logic cmd_target;
      logic closed_sensor_n;
      logic open_sensor_n;
   } item_type;

   typedef struct packed {
      logic       relay_on;
      logic       report_valid;
      logic [1:0] report_code;
      logic       busy_res;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/core/gdpc_req_if.sv @@
`default_nettype none

interface gdpc_req_if;
   logic valid;
   logic ready;
   logic cmd_valid;
   logic cmd_target;
   logic closed_sensor_n;
   logic open_sensor_n;

   modport source (output valid, output cmd_valid, output cmd_target,
                   output closed_sensor_n, output open_sensor_n, input ready);
   modport sink   (input valid, input cmd_valid, input cmd_target,
                   input closed_sensor_n, input open_sensor_n, output ready);
endinterface

`default_nettype wire

@@ rtl/core/gdpc_rsp_if.sv @@
`default_nettype none

interface gdpc_rsp_if;
   logic       valid;
   logic       ready;
   logic       relay_on;
   logic       report_valid;
   logic [1:0] report_code;
   logic       busy_res;

   modport source (output valid, output relay_on, output report_valid,
                   output report_code, output busy_res, input ready);
   modport sink   (input valid, input relay_on, input report_valid,
                   input report_code, input busy_res, output ready);
endinterface

`default_nettype wire

@@ rtl/core/gdpc_csr_if.sv @@
`default_nettype none

interface gdpc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/gdpc_csr_regs.sv @@
`default_nettype none

// Holds the three configuration registers; writes to an unused index are dropped.
module gdpc_csr_regs (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [1:0]       wr_index,
   input  wire logic [15:0]      wr_data,
   output gdpc_pkg::cfg_type     cfg
);

   gdpc_pkg::cfg_type cfg_ff;
   gdpc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            gdpc_pkg::CsrTimeoutTicks: cfg_in.timeout_ticks = wr_data;
            gdpc_pkg::CsrPulseTicks:   cfg_in.pulse_ticks   = wr_data;
            gdpc_pkg::CsrMaxPulses:
               cfg_in.max_pulses = wr_data[gdpc_pkg::CountWidth-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks <= gdpc_pkg::TimeoutTicksReset;
         cfg_ff.pulse_ticks   <= gdpc_pkg::PulseTicksReset;
         cfg_ff.max_pulses    <= gdpc_pkg::MaxPulsesReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/core/gdpc_step.sv @@
`default_nettype none

// Door state and its one-tick update. The result is combinational from the
// current state and the item; the state moves on when step_en is high.
module gdpc_step (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step_en,
   input  wire gdpc_pkg::cfg_type    cfg,
   input  wire gdpc_pkg::item_type   item,
   output gdpc_pkg::result_type      result
);

   logic                              action_ff, action_in;
   logic                              target_ff, target_in;
   logic [gdpc_pkg::CountWidth-1:0]   count_ff, count_in;
   logic [gdpc_pkg::TicksWidth-1:0]   elapsed_ff, elapsed_in;
   logic                              expired_ff, expired_in;
   logic [gdpc_pkg::TicksWidth-1:0]   remain_ff, remain_in;

   logic                              at_closed;
   logic                              at_open;
   logic                              at_target;

   assign at_closed = !item.closed_sensor_n && item.open_sensor_n;
   assign at_open   = item.closed_sensor_n && !item.open_sensor_n;
   assign at_target = target_ff ? at_open : at_closed;

   always_comb begin
      action_in  = action_ff;
      target_in  = target_ff;
      count_in   = count_ff;
      elapsed_in = elapsed_ff;
      expired_in = expired_ff;
      remain_in  = remain_ff;
      result.relay_on     = 1'b0;
      result.report_valid = 1'b0;
      result.report_code  = gdpc_pkg::CodeClosed;

      if (!action_ff) begin
         if (item.cmd_valid) begin
            target_in = item.cmd_target;
            count_in  = '0;
            action_in = 1'b1;
         end
      end else if (remain_ff != '0) begin
         result.relay_on = 1'b1;
         remain_in = remain_ff - 1'b1;
      end else if (!expired_ff) begin
         if (elapsed_ff != '1) begin
            elapsed_in = elapsed_ff + 1'b1;
         end
         if (elapsed_in >= cfg.timeout_ticks) begin
            expired_in = 1'b1;
         end
      end else if (at_target) begin
         result.report_valid = 1'b1;
         result.report_code  = target_ff ? gdpc_pkg::CodeOpened : gdpc_pkg::CodeClosed;
         count_in  = '0;
         action_in = 1'b0;
      end else if (count_ff >= cfg.max_pulses) begin
         result.report_valid = 1'b1;
         result.report_code  = gdpc_pkg::CodeError;
         count_in  = '0;
         action_in = 1'b0;
      end else begin
         // Start a pulse: this tick already counts as the first relay tick.
         result.relay_on = 1'b1;
         remain_in  = (cfg.pulse_ticks == '0) ? '0 : cfg.pulse_ticks - 1'b1;
         expired_in = 1'b0;
         elapsed_in = '0;
         count_in   = count_ff + 1'b1;
      end

      result.busy_res = action_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         action_ff  <= 1'b0;
         target_ff  <= 1'b0;
         count_ff   <= '0;
         elapsed_ff <= '0;
         expired_ff <= 1'b1;
         remain_ff  <= '0;
      end else if (step_en) begin
         action_ff  <= action_in;
         target_ff  <= target_in;
         count_ff   <= count_in;
         elapsed_ff <= elapsed_in;
         expired_ff <= expired_in;
         remain_ff  <= remain_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/garage_door_pulse_controller.sv @@
`default_nettype none

// Channel  Role    Beat carries
// -------  ------  ---------------------------------------------------------
// req_ch   sink    one tick: cmd_valid, cmd_target, closed/open sensors (n)
// rsp_ch   source  one result per tick: relay_on, report_valid/code, busy_res
// csr_ch   sink    register write: index (0 timeout, 1 pulse, 2 max), data
//
// Each request beat yields exactly one response beat, which passes through the
// input register and then the result register before it can be taken.
// Throughput is one beat per cycle while the response side is not stalled.
// Reset is synchronous and active high; it restores the register defaults and
// leaves the door idle with the timeout marked as expired.
// A stalled response holds the pipeline; req_ch.ready drops only when both stages are full.
module garage_door_pulse_controller (
   input  wire logic   clock,
   input  wire logic   reset,
   gdpc_req_if.sink    req_ch,
   gdpc_rsp_if.source  rsp_ch,
   gdpc_csr_if.sink    csr_ch
);

   gdpc_pkg::cfg_type    cfg;
   gdpc_pkg::item_type   item_ff, item_in;
   gdpc_pkg::result_type step_result;
   gdpc_pkg::result_type rsp_ff;

   logic item_valid_ff;
   logic rsp_valid_ff;
   logic out_advance;
   logic step_en;

   // Writes always taken; software must write only while idle; the block does not check.
   assign csr_ch.ready = 1'b1;

   gdpc_csr_regs u_csr_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   // The result register can take a new beat when it is empty or being drained.
   assign out_advance = !rsp_valid_ff || rsp_ch.ready;
   assign step_en     = item_valid_ff && out_advance;
   assign req_ch.ready = !item_valid_ff || out_advance;

   always_comb begin
      item_in.cmd_valid       = req_ch.cmd_valid;
      item_in.cmd_target      = req_ch.cmd_target;
      item_in.closed_sensor_n = req_ch.closed_sensor_n;
      item_in.open_sensor_n   = req_ch.open_sensor_n;
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         item_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         item_ff <= item_in;
      end
   end

   // The step unit updates the door state only when its beat moves on into the
   // result register, so a stalled beat is never applied twice.
   gdpc_step u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .cfg     (cfg),
      .item    (item_ff),
      .result  (step_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_advance) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.relay_on     = rsp_ff.relay_on;
   assign rsp_ch.report_valid = rsp_ff.report_valid;
   assign rsp_ch.report_code  = rsp_ff.report_code;
   assign rsp_ch.busy_res     = rsp_ff.busy_res;

endmodule

`default_nettype wire

@@ test/garage_door_pulse_controller_tb.sv @@
`default_nettype none

module garage_door_pulse_controller_tb;

   // Index that decodes to no register; a write to it must change nothing.
   localparam logic [1:0] CsrUnused = 2'd3;

   // The watchdog gives up after this many cycles in which no beat moves on any channel.
   localparam int unsigned StuckLimit = 2000;
   // Least number of tick beats sent in the random part of the run.
   localparam int unsigned RandomItems = 620;
   // Longest stretch of ticks spent on one door action in the random part.
   localparam int unsigned EpisodeCap = 200;
   // Only the first few mismatches are printed in full.
   localparam int unsigned ReportLimit = 10;
   // The pipeline is two stages deep, so a handful of cycles covers any late beat.
   localparam int unsigned SettleCycles = 10;

   // Door phase codes of the model below.
   localparam logic DoorIdle   = 1'b0;
   localparam logic DoorMoving = 1'b1;

   logic clock;
   logic reset;

   gdpc_req_if req_bus ();
   gdpc_rsp_if rsp_bus ();
   gdpc_csr_if csr_bus ();

   garage_door_pulse_controller u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // Our own copy of the controller: its timing registers as they stand after the
   // last accepted write, and the door state after the last accepted tick beat.
   gdpc_pkg::cfg_type door_cfg = '{gdpc_pkg::TimeoutTicksReset, gdpc_pkg::PulseTicksReset,
                                   gdpc_pkg::MaxPulsesReset};
   logic        door_phase   = DoorIdle;
   logic        door_target  = 1'b0;
   logic [2:0]  door_pulses  = '0;
   logic [15:0] waited_ticks = '0;
   logic        wait_done    = 1'b1;
   logic [15:0] relay_left   = '0;

   // Results still owed by the block, oldest first, one per accepted tick beat.
   gdpc_pkg::result_type tick_results_q[$];

   int unsigned mismatches   = 0;
   int unsigned stuck_cycles = 0;
   // When clear, neither the tick sender nor the result receiver inserts gaps.
   bit          gaps_on      = 1'b1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advances the door state by one millisecond tick and returns what the block
   // should report for it. A check happens only once the timeout has run out
   // and no pulse is in progress; a miss either starts a new pulse or, when the
   // pulse budget is spent, ends the action with an error.
   function automatic gdpc_pkg::result_type door_tick(input gdpc_pkg::item_type tick);
      gdpc_pkg::result_type res;
      logic                 at_closed;
      logic                 at_open;
      res       = '0;
      // Only a clean one-hot sensor pattern counts as an end position.
      at_closed = !tick.closed_sensor_n && tick.open_sensor_n;
      at_open   = tick.closed_sensor_n && !tick.open_sensor_n;
      if (door_phase != DoorMoving) begin
         door_phase = DoorIdle;
         if (tick.cmd_valid) begin
            door_target = tick.cmd_target;
            door_pulses = '0;
            door_phase  = DoorMoving;
         end
      end else if (relay_left != '0) begin
         res.relay_on = 1'b1;
         relay_left   = relay_left - 16'd1;
      end else if (!wait_done) begin
         // The wait counter sticks at its top value rather than wrapping.
         if (waited_ticks != 16'hFFFF)
            waited_ticks = waited_ticks + 16'd1;
         if (waited_ticks >= door_cfg.timeout_ticks)
            wait_done = 1'b1;
      end else if ((at_closed && !door_target) || (at_open && door_target)) begin
         res.report_valid = 1'b1;
         res.report_code  = door_target ? gdpc_pkg::CodeOpened : gdpc_pkg::CodeClosed;
         door_pulses      = '0;
         door_phase       = DoorIdle;
      end else if (door_pulses >= door_cfg.max_pulses) begin
         res.report_valid = 1'b1;
         res.report_code  = gdpc_pkg::CodeError;
         door_pulses      = '0;
         door_phase       = DoorIdle;
      end else begin
         // The relay is on from this very tick, so a pulse length of zero
         // behaves exactly like a length of one.
         res.relay_on = 1'b1;
         relay_left   = (door_cfg.pulse_ticks == '0) ? '0
                                                     : door_cfg.pulse_ticks - 16'd1;
         wait_done    = 1'b0;
         waited_ticks = '0;
         door_pulses  = door_pulses + 3'd1;
      end
      res.busy_res = (door_phase == DoorMoving);
      return res;
   endfunction

   // Offers one tick beat, perhaps after a short gap, and records the result it
   // must cause once the block has taken it. Valid is left high afterwards so
   // that back-to-back beats need no extra assignment within one time step.
   task automatic send_tick(input logic cmd, input logic goal, input logic closed_n,
                            input logic open_n);
      gdpc_pkg::item_type tick;
      tick = '{cmd, goal, closed_n, open_n};
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.cmd_valid       <= tick.cmd_valid;
      req_bus.cmd_target      <= tick.cmd_target;
      req_bus.closed_sensor_n <= tick.closed_sensor_n;
      req_bus.open_sensor_n   <= tick.open_sensor_n;
      do @(posedge clock); while (!req_bus.ready);
      tick_results_q.push_back(door_tick(tick));
   endtask

   // Withdraws the tick stream and waits until every owed result has come back.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (tick_results_q.size() != 0)
         @(posedge clock);
   endtask

   // One register write beat. Valid stays high so that writes can follow each
   // other directly; the caller lowers it after the last one.
   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         gdpc_pkg::CsrTimeoutTicks: door_cfg.timeout_ticks = value;
         gdpc_pkg::CsrPulseTicks:   door_cfg.pulse_ticks   = value;
         gdpc_pkg::CsrMaxPulses:    door_cfg.max_pulses    = value[2:0];
         default: ;
      endcase
   endtask

   // Rewrites all three timing registers once the pipeline is empty.
   task automatic program_timing(input logic [15:0] timeout, input logic [15:0] pulse,
                                 input logic [2:0] budget);
      drain();
      write_reg(gdpc_pkg::CsrTimeoutTicks, timeout);
      write_reg(gdpc_pkg::CsrPulseTicks, pulse);
      write_reg(gdpc_pkg::CsrMaxPulses, {13'd0, budget});
      csr_bus.valid <= 1'b0;
   endtask

   // Mostly short spans so that actions finish quickly, now and then a longer one
   // or zero.
   function automatic logic [15:0] random_span(input int unsigned usual,
                                               input int unsigned rare);
      if ($urandom_range(0, 7) == 0)
         return 16'($urandom_range(0, rare));
      return 16'($urandom_range(1, usual));
   endfunction

   // With the registers as they come out of reset, a command whose target is
   // already reached is answered on the very next tick, since the timeout
   // starts out as expired.
   task automatic test_reset_defaults();
      send_tick(1'b1, 1'b0, 1'b0, 1'b1);
      send_tick(1'b0, 1'b0, 1'b0, 1'b1);
   endtask

   // Every sensor pattern against both targets. Each miss starts a one-tick
   // pulse, followed by one waiting tick on which a stray command is sent and
   // must be ignored because the block is busy.
   task automatic test_sensor_decode();
      logic [1:0] miss;
      program_timing(16'd1, 16'd1, 3'd7);
      // Closing: both high, both low and the open position all count as misses.
      send_tick(1'b1, 1'b0, 1'b1, 1'b1);
      for (int k = 0; k < 3; k++) begin
         miss = (k == 0) ? 2'b11 : (k == 1) ? 2'b00 : 2'b10;
         send_tick(1'b0, 1'b0, miss[1], miss[0]);
         send_tick(1'b1, 1'b1, 1'($urandom), 1'($urandom));
      end
      send_tick(1'b0, 1'b0, 1'b0, 1'b1);
      // Opening: the closed position is a miss, then the open one is reached.
      send_tick(1'b1, 1'b1, 1'b1, 1'b1);
      send_tick(1'b0, 1'b1, 1'b0, 1'b1);
      send_tick(1'b1, 1'b0, 1'($urandom), 1'($urandom));
      send_tick(1'b0, 1'b1, 1'b1, 1'b0);
   endtask

   // Zero pulse and timeout lengths, a pulse budget of one and of zero, and a
   // write to the unused index, which must leave the timing untouched.
   task automatic test_zero_registers();
      drain();
      write_reg(CsrUnused, 16'($urandom));
      program_timing(16'd0, 16'd0, 3'd1);
      send_tick(1'b1, 1'b0, 1'b1, 1'b1);
      send_tick(1'b0, 1'b0, 1'b1, 1'b1);
      send_tick(1'b0, 1'b0, 1'b1, 1'b1);
      send_tick(1'b0, 1'b0, 1'b0, 1'b0);
      // With no pulses allowed the first miss is already an error.
      program_timing(16'd0, 16'd0, 3'd0);
      send_tick(1'b1, 1'b1, 1'b0, 1'b1);
      send_tick(1'b0, 1'b0, 1'b0, 1'b1);
   endtask

   // The timeout is cut while the block is waiting out a long one: the wait
   // ends on the next tick, as the count already stands at the new limit.
   task automatic test_timeout_lowered();
      program_timing(16'hFFFF, 16'd1, 3'd1);
      send_tick(1'b1, 1'b1, 1'b1, 1'b1);
      send_tick(1'b0, 1'b0, 1'b1, 1'b1);
      send_tick(1'b0, 1'b0, 1'b1, 1'b1);
      send_tick(1'b0, 1'b0, 1'b1, 1'b1);
      program_timing(16'd2, 16'd1, 3'd1);
      send_tick(1'b0, 1'b0, 1'b0, 1'b0);
      send_tick(1'b0, 1'b0, 1'b1, 1'b0);
   endtask

   // Random door actions. Each action picks how many pulses the door needs
   // before it reaches its target; until then the sensors mostly show the
   // opposite end, with both-low, both-high and random patterns mixed in.
   // Stray commands arrive during actions, and the timing is reprogrammed now
   // and then between actions.
   task automatic test_random_traffic();
      int unsigned sent;
      int unsigned steps;
      int unsigned pick;
      int unsigned needed;
      logic        goal;
      logic        pos;
      logic        closed_n;
      logic        open_n;
      sent = 0;
      while (sent < RandomItems) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 3) == 0)
            program_timing(random_span(6, 60), random_span(3, 20), 3'($urandom_range(0, 7)));
         repeat ($urandom_range(0, 2)) begin
            send_tick(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
            sent++;
         end
         goal   = 1'($urandom);
         needed = $urandom_range(0, door_cfg.max_pulses + 1);
         send_tick(1'b1, goal, 1'($urandom), 1'($urandom));
         sent++;
         steps = 0;
         while (door_phase == DoorMoving && steps < EpisodeCap) begin
            pick = $urandom_range(0, 9);
            pos  = (door_pulses >= needed) ? goal : !goal;
            if (pick < 6) begin
               closed_n = pos;
               open_n   = !pos;
            end else if (pick == 6) begin
               closed_n = 1'b0;
               open_n   = 1'b0;
            end else if (pick == 7) begin
               closed_n = 1'b1;
               open_n   = 1'b1;
            end else begin
               closed_n = 1'($urandom);
               open_n   = 1'($urandom);
            end
            send_tick($urandom_range(0, 7) == 0, 1'($urandom), closed_n, open_n);
            sent++;
            steps++;
         end
      end
   endtask

   // Longer lengths with the door never arriving: one full pulse, one full
   // wait, then an error. This runs last and without gaps.
   task automatic test_long_extremes();
      gaps_on = 1'b0;
      program_timing(16'd40, 16'd30, 3'd1);
      send_tick(1'b1, 1'b1, 1'b1, 1'b1);
      while (door_phase == DoorMoving)
         send_tick($urandom_range(0, 15) == 0, 1'($urandom), 1'b0, 1'b0);
   endtask

   task automatic flag_field(input string field, input int unsigned want,
                             input int unsigned got);
      mismatches++;
      if (mismatches <= ReportLimit)
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
   endtask

   // Compares one result beat with the oldest owed result, field by field.
   task automatic check_result(input gdpc_pkg::result_type got);
      gdpc_pkg::result_type want;
      if (tick_results_q.size() == 0) begin
         mismatches++;
         if (mismatches <= ReportLimit)
            $display("%0t: result beat with none expected, actual %h", $time, got);
      end else begin
         want = tick_results_q.pop_front();
         if (got.relay_on !== want.relay_on)
            flag_field("relay_on", want.relay_on, got.relay_on);
         if (got.report_valid !== want.report_valid)
            flag_field("report_valid", want.report_valid, got.report_valid);
         if (got.report_code !== want.report_code)
            flag_field("report_code", want.report_code, got.report_code);
         if (got.busy_res !== want.busy_res)
            flag_field("busy_res", want.busy_res, got.busy_res);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         check_result('{rsp_bus.relay_on, rsp_bus.report_valid, rsp_bus.report_code,
                        rsp_bus.busy_res});
   end

   // The result side stalls in random bursts while gaps are on.
   int unsigned stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= $urandom_range(0, 7);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Any beat on any channel counts as progress; a long silence means the block
   // has hung.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == StuckLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      reset                   <= 1'b1;
      req_bus.valid           <= 1'b0;
      req_bus.cmd_valid       <= 1'b0;
      req_bus.cmd_target      <= 1'b0;
      req_bus.closed_sensor_n <= 1'b1;
      req_bus.open_sensor_n   <= 1'b1;
      csr_bus.valid           <= 1'b0;
      csr_bus.index           <= '0;
      csr_bus.data            <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_sensor_decode();
      test_zero_registers();
      test_timeout_lowered();
      test_random_traffic();
      test_long_extremes();

      // Let every owed result arrive, then allow a few cycles for any beat
      // the block should not have produced.
      drain();
      repeat (SettleCycles) @(posedge clock);
      if (mismatches == 0 && tick_results_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire

@@ garage_door_pulse_controller.f @@
rtl/core/gdpc_pkg.sv
rtl/core/gdpc_req_if.sv
rtl/core/gdpc_rsp_if.sv
rtl/core/gdpc_csr_if.sv
rtl/core/gdpc_csr_regs.sv
rtl/core/gdpc_step.sv
rtl/core/garage_door_pulse_controller.sv
test/garage_door_pulse_controller_tb.sv
